[design/vfv_pkg.sv]
`default_nettype none

package vfv_pkg;

    localparam int REG_W     = 5;
    localparam int COORD_W   = 4;
    localparam int FACE_W    = 6;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W    = 3;

    localparam logic [REG_W-1:0] SIZE_RESET = 5'd16;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

    localparam logic [STEP_W-1:0] STEP_SELF = 3'd0;
    localparam logic [STEP_W-1:0] STEP_XP   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_XM   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_YP   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_YM   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_ZP   = 3'd5;
    localparam logic [STEP_W-1:0] STEP_ZM   = 3'd6;

    typedef struct packed {
        logic               cmd;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_z;
        logic               solid_in;
    } t_in_item;

    typedef struct packed {
        logic              solid_out;
        logic [FACE_W-1:0] face_mask;
        logic              out_of_range;
    } t_out_item;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_READ,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear_we;
        logic take_item;
        logic mem_we;
        logic rd_issue;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic cmd_query;
        logic oor;
        logic read_last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

[design/vfv_ram.sv]
`default_nettype none

module vfv_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[design/vfv_ctrl.sv]
`default_nettype none

module vfv_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  vfv_pkg::t_dp_stat  i_stat,
    output vfv_pkg::t_dp_cmd   o_cmd,
    output logic               o_in_ready
);

    import vfv_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.cmd_query && !i_stat.oor) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                if (i_stat.read_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_we = 1'b1;
            end
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.take_item = i_in_valid;
            end
            S_DECIDE: begin
                o_cmd.mem_we = !i_stat.cmd_query && !i_stat.oor;
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
            end
            S_DRAIN: begin
                o_cmd = '0;
            end
            S_DONE: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/vfv_dp.sv]
`default_nettype none

module vfv_dp #(
    parameter int MAX_X = 16,
    parameter int MAX_Y = 16,
    parameter int MAX_Z = 16,
    parameter int AW    = 12
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  vfv_pkg::t_dp_cmd                      i_cmd,
    output vfv_pkg::t_dp_stat                     o_stat,
    input  vfv_pkg::t_in_item                     i_in_item,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output vfv_pkg::t_out_item                    o_out_item,
    input  wire                                   i_cfg_valid,
    input  wire [vfv_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire [vfv_pkg::REG_W-1:0]              i_cfg_data,
    output logic                                  o_mem_we,
    output logic [AW-1:0]                         o_mem_waddr,
    output logic                                  o_mem_wdata,
    output logic [AW-1:0]                         o_mem_raddr,
    input  wire                                   i_mem_rdata
);

    import vfv_pkg::*;

    localparam int AX = $clog2(MAX_X);
    localparam int AY = $clog2(MAX_Y);
    localparam int AZ = $clog2(MAX_Z);

    function automatic logic at_or_beyond(input logic [REG_W-1:0] v,
                                          input logic [REG_W-1:0] r,
                                          input int cap);
        logic res;
        if (int'(r) > cap) begin
            res = int'(v) >= cap;
        end else begin
            res = v >= r;
        end
        return res;
    endfunction

    logic [REG_W-1:0]  r_size_x;
    logic [REG_W-1:0]  r_size_y;
    logic [REG_W-1:0]  r_size_z;
    t_in_item          r_item;
    logic [AW-1:0]     r_clr_addr;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] r_rd_step;
    logic              r_rd_pend;
    logic              r_self;
    logic [FACE_W-1:0] r_nb;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [REG_W-1:0]   w_x;
    logic [REG_W-1:0]   w_y;
    logic [REG_W-1:0]   w_z;
    logic               w_oor;
    logic [FACE_W-1:0]  w_edge;
    logic [COORD_W-1:0] w_nx;
    logic [COORD_W-1:0] w_ny;
    logic [COORD_W-1:0] w_nz;
    t_out_item          w_res;

    assign w_x = {1'b0, r_item.coord_x};
    assign w_y = {1'b0, r_item.coord_y};
    assign w_z = {1'b0, r_item.coord_z};

    assign w_oor = at_or_beyond(w_x, r_size_x, MAX_X)
                || at_or_beyond(w_y, r_size_y, MAX_Y)
                || at_or_beyond(w_z, r_size_z, MAX_Z);

    assign w_edge[0] = at_or_beyond(w_x + 5'd1, r_size_x, MAX_X);
    assign w_edge[1] = (w_x == '0);
    assign w_edge[2] = at_or_beyond(w_y + 5'd1, r_size_y, MAX_Y);
    assign w_edge[3] = (w_y == '0);
    assign w_edge[4] = at_or_beyond(w_z + 5'd1, r_size_z, MAX_Z);
    assign w_edge[5] = (w_z == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_RESET;
            r_size_y <= SIZE_RESET;
            r_size_z <= SIZE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SIZE_X: r_size_x <= i_cfg_data;
                CFG_SIZE_Y: r_size_y <= i_cfg_data;
                CFG_SIZE_Z: r_size_z <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_we) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= STEP_SELF;
            r_rd_pend <= 1'b0;
            r_rd_step <= STEP_SELF;
        end else begin
            if (i_cmd.take_item) begin
                r_step <= STEP_SELF;
            end else if (i_cmd.rd_issue) begin
                r_step <= r_step + 1'b1;
            end
            r_rd_pend <= i_cmd.rd_issue;
            r_rd_step <= r_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_pend) begin
            unique case (r_rd_step)
                STEP_SELF: r_self  <= i_mem_rdata;
                STEP_XP:   r_nb[0] <= i_mem_rdata;
                STEP_XM:   r_nb[1] <= i_mem_rdata;
                STEP_YP:   r_nb[2] <= i_mem_rdata;
                STEP_YM:   r_nb[3] <= i_mem_rdata;
                STEP_ZP:   r_nb[4] <= i_mem_rdata;
                STEP_ZM:   r_nb[5] <= i_mem_rdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_nx = r_item.coord_x;
        w_ny = r_item.coord_y;
        w_nz = r_item.coord_z;
        unique case (r_step)
            STEP_XP: w_nx = r_item.coord_x + 1'b1;
            STEP_XM: w_nx = r_item.coord_x - 1'b1;
            STEP_YP: w_ny = r_item.coord_y + 1'b1;
            STEP_YM: w_ny = r_item.coord_y - 1'b1;
            STEP_ZP: w_nz = r_item.coord_z + 1'b1;
            STEP_ZM: w_nz = r_item.coord_z - 1'b1;
            default: begin
            end
        endcase
    end

    assign o_mem_raddr = {AZ'(w_nz), AY'(w_ny), AX'(w_nx)};
    assign o_mem_we    = i_cmd.clear_we || i_cmd.mem_we;
    assign o_mem_waddr = i_cmd.clear_we ? r_clr_addr
                       : {AZ'(r_item.coord_z), AY'(r_item.coord_y), AX'(r_item.coord_x)};
    assign o_mem_wdata = i_cmd.clear_we ? 1'b0 : r_item.solid_in;

    always_comb begin
        w_res = '0;
        if (r_item.cmd == CMD_WRITE) begin
            w_res.solid_out    = r_item.solid_in;
            w_res.out_of_range = w_oor;
        end else if (w_oor) begin
            w_res.out_of_range = 1'b1;
        end else begin
            w_res.solid_out = r_self;
            w_res.face_mask = w_edge | ~r_nb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign o_stat.clear_last = &r_clr_addr;
    assign o_stat.cmd_query  = (r_item.cmd == CMD_QUERY);
    assign o_stat.oor        = w_oor;
    assign o_stat.read_last  = (r_step == STEP_ZM);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

[design/voxel_face_visibility_store.sv]
`default_nettype none

// Voxel occupancy map with face-visibility queries. Each voxel keeps one solid
// bit in a single-bit RAM addressed {z, y, x} with power-of-two strides, so the
// RAM has 2**(clog2(MAX_X)+clog2(MAX_Y)+clog2(MAX_Z)) entries (4096 by default).
// After reset the block sweeps that RAM to zero, one entry per cycle, and holds
// o_in_ready low until the sweep ends; configuration writes are taken at any
// time. A write or out-of-range item passes S_DECIDE and S_DONE before the next
// transfer. A query issues seven reads (the voxel and its six neighbors) through
// the one RAM read port in S_READ, then passes S_DRAIN and S_DONE. A finished
// result sits in an output register, so the next item is taken while it waits.
// Program size_x/y/z only while the block is idle.

module voxel_face_visibility_store #(
    parameter int MAX_X = 16,
    parameter int MAX_Y = 16,
    parameter int MAX_Z = 16
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  vfv_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output vfv_pkg::t_out_item            o_out_item,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire [vfv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [vfv_pkg::REG_W-1:0]      i_cfg_data
);

    import vfv_pkg::*;

    localparam int AW = $clog2(MAX_X) + $clog2(MAX_Y) + $clog2(MAX_Z);

    t_dp_cmd       w_cmd;
    t_dp_stat      w_stat;
    logic          w_mem_we;
    logic [AW-1:0] w_mem_waddr;
    logic          w_mem_wdata;
    logic [AW-1:0] w_mem_raddr;
    logic          w_mem_rdata;

    assign o_cfg_ready = 1'b1;

    vfv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (o_in_ready)
    );

    vfv_dp #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y),
        .MAX_Z (MAX_Z),
        .AW    (AW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    vfv_ram #(
        .WIDTH (1),
        .DEPTH (1 << AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

`ifndef ASSERT_OFF
    a_no_take_during_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear_we |-> !o_in_ready)
        else $error("input ready during clearing pass");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> w_stat.out_free)
        else $error("result loaded over an untaken result");

    a_map_write_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.mem_we |-> (!w_stat.cmd_query && !w_stat.oor))
        else $error("map written by a query or out-of-range item");

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while one is in progress");
`endif

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import vfv_pkg::*;

    localparam int MAP_DIM     = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 400;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int FACE_XP = 0;
    localparam int FACE_XM = 1;
    localparam int FACE_YP = 2;
    localparam int FACE_YM = 3;
    localparam int FACE_ZP = 4;
    localparam int FACE_ZM = 5;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_item   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_item;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [REG_W-1:0]     i_cfg_data  = '0;

    // shadow of the chunk map and the size registers
    bit               occ_map [MAP_DIM * MAP_DIM * MAP_DIM];
    logic [REG_W-1:0] ext_x = SIZE_RESET;
    logic [REG_W-1:0] ext_y = SIZE_RESET;
    logic [REG_W-1:0] ext_z = SIZE_RESET;

    t_in_item  voxel_ops_q[$];
    t_out_item expected_faces_q[$];
    t_out_item want_item;

    int in_issued    = 0;
    int in_xfer_cnt  = 0;
    int cfg_xfer_cnt = 0;
    int cycle_cnt    = 0;
    int mismatches   = 0;
    int tx_gap       = 0;
    int rx_gap       = 0;
    int rx_hold_left = 0;
    bit rx_hold_req  = 1'b0;
    bit calm         = 1'b0;
    int gen_ex       = MAP_DIM;
    int gen_ey       = MAP_DIM;
    int gen_ez       = MAP_DIM;

    voxel_face_visibility_store u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int eff_extent(logic [REG_W-1:0] r);
        return (r > MAP_DIM) ? MAP_DIM : int'(r);
    endfunction

    function automatic int voxel_addr(int x, int y, int z);
        return x + MAP_DIM * (y + MAP_DIM * z);
    endfunction

    function automatic t_out_item apply_voxel_item(t_in_item it);
        t_out_item r;
        int        x;
        int        y;
        int        z;
        int        ex;
        int        ey;
        int        ez;
        logic      oor;
        x   = it.coord_x;
        y   = it.coord_y;
        z   = it.coord_z;
        ex  = eff_extent(ext_x);
        ey  = eff_extent(ext_y);
        ez  = eff_extent(ext_z);
        oor = (x >= ex) || (y >= ey) || (z >= ez);
        r   = '0;
        r.out_of_range = oor;
        if (it.cmd == CMD_WRITE) begin
            r.solid_out = it.solid_in;
            if (!oor) begin
                occ_map[voxel_addr(x, y, z)] = it.solid_in;
            end
        end else if (!oor) begin
            r.solid_out = occ_map[voxel_addr(x, y, z)];
            r.face_mask[FACE_XP] = (x + 1 >= ex) || !occ_map[voxel_addr(x + 1, y, z)];
            r.face_mask[FACE_XM] = (x == 0) || !occ_map[voxel_addr(x - 1, y, z)];
            r.face_mask[FACE_YP] = (y + 1 >= ey) || !occ_map[voxel_addr(x, y + 1, z)];
            r.face_mask[FACE_YM] = (y == 0) || !occ_map[voxel_addr(x, y - 1, z)];
            r.face_mask[FACE_ZP] = (z + 1 >= ez) || !occ_map[voxel_addr(x, y, z + 1)];
            r.face_mask[FACE_ZM] = (z == 0) || !occ_map[voxel_addr(x, y, z - 1)];
        end
        return r;
    endfunction

    // sender: hold valid and payload until the transfer, then maybe idle
    always @(negedge i_clk) begin
        if (in_xfer_cnt == in_issued) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_in_valid <= 1'b0;
            end else if (voxel_ops_q.size() != 0) begin
                i_in_item  <= voxel_ops_q.pop_front();
                i_in_valid <= 1'b1;
                in_issued++;
                if (!calm && $urandom_range(9, 0) == 0) begin
                    tx_gap = $urandom_range(17, 1);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off on request
    always @(negedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_req  = 1'b0;
            rx_hold_left = LONG_HOLD;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(11, 0) == 0) begin
            rx_gap = $urandom_range(16, 0);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("simulation failed");
            $finish;
        end else if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SIZE_X: ext_x = i_cfg_data;
                    CFG_SIZE_Y: ext_y = i_cfg_data;
                    CFG_SIZE_Z: ext_z = i_cfg_data;
                    default: ;
                endcase
                cfg_xfer_cnt++;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_faces_q.size() == 0) begin
                    $display("%0t: result %h with nothing expected", $time, o_out_item);
                    mismatches++;
                end else begin
                    want_item = expected_faces_q.pop_front();
                    if (o_out_item.solid_out !== want_item.solid_out) begin
                        $display("%0t: solid_out expected %0d got %0d", $time,
                                 want_item.solid_out, o_out_item.solid_out);
                        mismatches++;
                    end
                    if (o_out_item.face_mask !== want_item.face_mask) begin
                        $display("%0t: face_mask expected %b got %b", $time,
                                 want_item.face_mask, o_out_item.face_mask);
                        mismatches++;
                    end
                    if (o_out_item.out_of_range !== want_item.out_of_range) begin
                        $display("%0t: out_of_range expected %0d got %0d", $time,
                                 want_item.out_of_range, o_out_item.out_of_range);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                expected_faces_q.push_back(apply_voxel_item(i_in_item));
                in_xfer_cnt++;
            end
        end
    end

    task automatic push_item(logic cmd, int x, int y, int z, logic solid);
        t_in_item it;
        it.cmd      = cmd;
        it.coord_x  = x[COORD_W-1:0];
        it.coord_y  = y[COORD_W-1:0];
        it.coord_z  = z[COORD_W-1:0];
        it.solid_in = solid;
        voxel_ops_q.push_back(it);
    endtask

    function automatic int pick_origin(int e);
        return (e > 4) ? int'($urandom_range(e - 4, 0)) : 0;
    endfunction

    // mostly clustered traffic so neighbors are often solid, some anywhere
    task automatic push_random_items(int n);
        int ox;
        int oy;
        int oz;
        int x;
        int y;
        int z;
        ox = 0;
        oy = 0;
        oz = 0;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) begin
                ox = pick_origin(gen_ex);
                oy = pick_origin(gen_ey);
                oz = pick_origin(gen_ez);
            end
            if ($urandom_range(99, 0) < 12) begin
                x = $urandom_range(15, 0);
                y = $urandom_range(15, 0);
                z = $urandom_range(15, 0);
            end else begin
                x = ox + $urandom_range(3, 0);
                y = oy + $urandom_range(3, 0);
                z = oz + $urandom_range(3, 0);
            end
            push_item(($urandom_range(99, 0) < 45) ? CMD_WRITE : CMD_QUERY, x, y, z,
                      $urandom_range(9, 0) < 7);
        end
    endtask

    task automatic wait_drained();
        while (voxel_ops_q.size() != 0 || in_xfer_cnt != in_issued
               || expected_faces_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
        int target;
        target = cfg_xfer_cnt + 1;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do begin
            @(negedge i_clk);
        end while (cfg_xfer_cnt != target);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_sizes(logic [REG_W-1:0] sx, logic [REG_W-1:0] sy,
                             logic [REG_W-1:0] sz);
        wait_drained();
        repeat (20) @(negedge i_clk);
        write_cfg(CFG_SIZE_X, sx);
        write_cfg(CFG_SIZE_Y, sy);
        write_cfg(CFG_SIZE_Z, sz);
        gen_ex = eff_extent(sx);
        gen_ey = eff_extent(sy);
        gen_ez = eff_extent(sz);
    endtask

    task automatic request_long_hold(int after_items);
        while (in_xfer_cnt < after_items) begin
            @(posedge i_clk);
        end
        rx_hold_req = 1'b1;
    endtask

    initial begin
        logic [REG_W-1:0] rx;
        logic [REG_W-1:0] ry;
        logic [REG_W-1:0] rz;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_item(CMD_QUERY, 0, 0, 0, 1'b0);
        push_item(CMD_WRITE, 0, 0, 0, 1'b1);
        push_item(CMD_QUERY, 0, 0, 0, 1'b1);
        push_item(CMD_WRITE, 1, 0, 0, 1'b1);
        push_item(CMD_WRITE, 0, 1, 0, 1'b1);
        push_item(CMD_WRITE, 0, 0, 1, 1'b1);
        push_item(CMD_QUERY, 0, 0, 0, 1'b0);
        push_item(CMD_WRITE, 15, 15, 15, 1'b1);
        push_item(CMD_WRITE, 14, 15, 15, 1'b1);
        push_item(CMD_QUERY, 15, 15, 15, 1'b0);
        push_item(CMD_QUERY, 14, 15, 15, 1'b1);
        push_item(CMD_WRITE, 1, 0, 0, 1'b0);
        push_item(CMD_QUERY, 0, 0, 0, 1'b0);
        push_random_items(230);
        request_long_hold(in_xfer_cnt + 60);

        set_sizes(5'd4, 5'd3, 5'd2);
        write_cfg(CFG_SPARE, 5'd1);
        push_item(CMD_QUERY, 4, 0, 0, 1'b0);
        push_item(CMD_WRITE, 0, 3, 0, 1'b1);
        push_item(CMD_QUERY, 0, 3, 0, 1'b0);
        push_item(CMD_QUERY, 3, 2, 1, 1'b0);
        push_item(CMD_QUERY, 0, 0, 0, 1'b0);
        push_random_items(240);
        request_long_hold(in_xfer_cnt + 80);

        set_sizes(5'd0, 5'd31, 5'd17);
        push_item(CMD_WRITE, 0, 0, 0, 1'b1);
        push_item(CMD_QUERY, 0, 0, 0, 1'b0);
        push_item(CMD_QUERY, 15, 15, 15, 1'b1);
        push_random_items(60);

        set_sizes(5'd1, 5'd1, 5'd1);
        push_item(CMD_QUERY, 0, 0, 0, 1'b0);
        push_random_items(60);

        set_sizes(5'd31, 5'd16, 5'd1);
        push_random_items(100);

        for (int p = 0; p < 4; p++) begin
            rx = 5'($urandom_range(16, 1));
            ry = 5'($urandom_range(16, 1));
            rz = (p == 2) ? 5'($urandom_range(31, 0)) : 5'($urandom_range(16, 1));
            set_sizes(rx, ry, rz);
            push_random_items(100);
        end

        set_sizes(5'd16, 5'd16, 5'd16);
        @(posedge i_clk);
        calm = 1'b1;
        push_random_items(150);

        wait_drained();
        repeat (30) @(negedge i_clk);
        if (mismatches == 0 && expected_faces_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
